// File: sv/mpas_pkg.sv
// ============================================================================
// mpas_pkg
// Shared types and constants for the mold pin actuator sequencer core.
// ============================================================================
package mpas_pkg;

    // Width of the on-delay timer count and preset
    localparam int TIME_WIDTH = 16;

    // Configuration register widths
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    // Alarm timeout used when the register holds zero
    localparam logic [CFG_WIDTH-1:0] DEFAULT_ALARM_TIME = 16'd1000;

    // Stream payload widths (whole bytes)
    localparam int IN_DATA_WIDTH  = 16;
    localparam int OUT_DATA_WIDTH = 24;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_FORWARD_DELAY   = 2'd0,
        CFG_BACKWARD_DELAY  = 2'd1,
        CFG_BACK_ALARM_TIME = 2'd2
    } cfg_index_t;

    // Input commands
    typedef enum logic [2:0] {
        CMD_NONE           = 3'd0,
        CMD_FORWARD        = 3'd1,
        CMD_BACKWARD       = 3'd2,
        CMD_NORMAL_STOP    = 3'd3,
        CMD_EMERGENCY_STOP = 3'd4
    } cmd_t;

    // Sequencer steps
    typedef enum logic [3:0] {
        STEP_IDLE       = 4'd0,
        STEP_FW_CHECK   = 4'd1,
        STEP_FW_DELAY   = 4'd2,
        STEP_FW_DRIVE   = 4'd3,
        STEP_FW_DONE    = 4'd4,
        STEP_BW_CHECK   = 4'd5,
        STEP_BW_DELAY   = 4'd6,
        STEP_BW_ARM     = 4'd7,
        STEP_BW_WATCH   = 4'd8,
        STEP_BW_DONE    = 4'd9,
        STEP_NORMAL     = 4'd10,
        STEP_EMERGENCY  = 4'd11,
        STEP_ERROR      = 4'd12
    } step_t;

endpackage

// File: sv/mold_pin_actuator_sequencer_core.sv
// ============================================================================
// mold_pin_actuator_sequencer_core
// Step sequencer for a mold pin actuator: forward and backward phases with
// optional delays, an on-delay timer and a back-limit alarm timeout.
// ============================================================================
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+---------------------------------
//  s_*     | in        | s_tvalid/s_tready| command, elapsed, limit, enable,
//          |           |                  | auto flag (one control cycle)
//  m_*     | out       | m_tvalid/m_tready| step, pin drive, active, alarm,
//          |           |                  | phase elapsed time
//  cfg_*   | in        | cfg_we           | delay and alarm time registers
//
//  Each item passes through the input register, then through the step
//  logic into the result register. One item per clock sustained unless
//  the result side stalls; the step logic plus timer add is one pass.
//  The input register takes a new item whenever it is empty or moving on,
//  so a stalled result holds at most one more item. Reset (rst_n low) at once
//  clears step, latches, timer and delays and sets the default alarm time.
// ============================================================================
module mold_pin_actuator_sequencer_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [mpas_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mpas_pkg::CFG_WIDTH-1:0]       cfg_data,
    // Input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [2:0] command, [10:3] elapsed, [11] back_limit, [12] pin_enabled,
    // [13] auto_mode, [15:14] zero
    input  logic [mpas_pkg::IN_DATA_WIDTH-1:0]   s_tdata,
    // Result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [3:0] step_code, [4] pin_forward, [5] action_active,
    // [6] not_at_back_alarm, [22:7] phase_elapsed, [23] zero
    output logic [mpas_pkg::OUT_DATA_WIDTH-1:0]  m_tdata
);

    localparam int TW = mpas_pkg::TIME_WIDTH;

    // Configuration registers
    logic [mpas_pkg::CFG_WIDTH-1:0] fwd_delay_reg;
    logic [mpas_pkg::CFG_WIDTH-1:0] bwd_delay_reg;
    logic [mpas_pkg::CFG_WIDTH-1:0] alarm_time_reg;

    // Input register
    logic                               in_valid_reg;
    logic [mpas_pkg::IN_DATA_WIDTH-1:0] in_data_reg;

    // Result register
    logic                                out_valid_reg;
    logic [mpas_pkg::OUT_DATA_WIDTH-1:0] out_data_reg;
    logic [mpas_pkg::OUT_DATA_WIDTH-1:0] out_data_next;

    // Sequencer state
    mpas_pkg::step_t step_reg;
    mpas_pkg::step_t step_next;
    logic            drive_reg;
    logic            drive_next;
    logic            active_reg;
    logic            active_next;
    logic            run_reg;
    logic            run_next;
    logic [TW-1:0]   count_reg;
    logic [TW-1:0]   count_next;
    logic [TW-1:0]   preset_reg;
    logic [TW-1:0]   preset_next;
    logic            alarm_reg;
    logic            alarm_next;

    // Unpacked fields of the held item
    logic [2:0] cmd;
    logic [7:0] elapsed;
    logic       back_limit;
    logic       pin_enabled;
    logic       auto_mode;

    // Per-step intermediates
    mpas_pkg::step_t step_forced;
    logic [TW:0]     count_sum;
    logic            q;
    logic [15:0]     disp;
    logic [mpas_pkg::CFG_WIDTH-1:0] alarm_preset;
    logic            advance;

    assign cmd         = in_data_reg[2:0];
    assign elapsed     = in_data_reg[10:3];
    assign back_limit  = in_data_reg[11];
    assign pin_enabled = in_data_reg[12];
    assign auto_mode   = in_data_reg[13];

    // Move the held item through the step logic when the result slot frees
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_delay_reg  <= '0;
            bwd_delay_reg  <= '0;
            alarm_time_reg <= mpas_pkg::DEFAULT_ALARM_TIME;
        end
        else if (cfg_we)
        begin
            case (mpas_pkg::cfg_index_t'(cfg_index))
                mpas_pkg::CFG_FORWARD_DELAY:   fwd_delay_reg  <= cfg_data;
                mpas_pkg::CFG_BACKWARD_DELAY:  bwd_delay_reg  <= cfg_data;
                mpas_pkg::CFG_BACK_ALARM_TIME: alarm_time_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Force the step by command
    always_comb
    begin
        case (mpas_pkg::cmd_t'(cmd))
            mpas_pkg::CMD_FORWARD:        step_forced = mpas_pkg::STEP_FW_CHECK;
            mpas_pkg::CMD_BACKWARD:       step_forced = mpas_pkg::STEP_BW_CHECK;
            mpas_pkg::CMD_NORMAL_STOP:    step_forced = mpas_pkg::STEP_NORMAL;
            mpas_pkg::CMD_EMERGENCY_STOP: step_forced = mpas_pkg::STEP_EMERGENCY;
            default:                      step_forced = step_reg;
        endcase
    end

    // Advance the timer: accumulate and saturate at the preset
    assign count_sum = {1'b0, count_reg} + (TW+1)'(elapsed);
    always_comb
    begin
        if (!run_reg)
            count_next = '0;
        else if (count_sum > {1'b0, preset_reg})
            count_next = preset_reg;
        else
            count_next = count_sum[TW-1:0];
    end
    assign q = run_reg && (count_next >= preset_reg);

    assign alarm_preset = (alarm_time_reg != '0) ? alarm_time_reg
                                                 : mpas_pkg::DEFAULT_ALARM_TIME;

    // Next step
    always_comb
    begin
        step_next = step_forced;
        case (step_forced)
            mpas_pkg::STEP_FW_CHECK:
            begin
                if (!pin_enabled)
                    step_next = mpas_pkg::STEP_FW_DONE;
                else if (fwd_delay_reg != '0)
                    step_next = mpas_pkg::STEP_FW_DELAY;
                else
                    step_next = mpas_pkg::STEP_FW_DRIVE;
            end
            mpas_pkg::STEP_FW_DELAY:
            begin
                if (q)
                    step_next = mpas_pkg::STEP_FW_DRIVE;
            end
            mpas_pkg::STEP_FW_DRIVE:
                step_next = mpas_pkg::STEP_FW_DONE;
            mpas_pkg::STEP_BW_CHECK:
            begin
                if (!pin_enabled)
                    step_next = mpas_pkg::STEP_BW_DONE;
                else if (bwd_delay_reg != '0)
                    step_next = mpas_pkg::STEP_BW_DELAY;
                else
                    step_next = mpas_pkg::STEP_BW_ARM;
            end
            mpas_pkg::STEP_BW_DELAY:
            begin
                if (q)
                    step_next = mpas_pkg::STEP_BW_ARM;
            end
            mpas_pkg::STEP_BW_ARM:
                step_next = mpas_pkg::STEP_BW_WATCH;
            mpas_pkg::STEP_BW_WATCH:
            begin
                // alarm wins over the limit switch
                if (q)
                    step_next = mpas_pkg::STEP_ERROR;
                else if (back_limit)
                    step_next = mpas_pkg::STEP_BW_DONE;
            end
            mpas_pkg::STEP_NORMAL,
            mpas_pkg::STEP_EMERGENCY:
                step_next = mpas_pkg::STEP_IDLE;
            default: ;
        endcase

        // Abort the forward phase on disable in auto
        if ((step_next == mpas_pkg::STEP_FW_DELAY || step_next == mpas_pkg::STEP_FW_DRIVE)
            && !pin_enabled && auto_mode)
            step_next = mpas_pkg::STEP_NORMAL;
    end

    // Latches, timer control and display value
    always_comb
    begin
        drive_next  = drive_reg;
        active_next = active_reg;
        run_next    = run_reg;
        preset_next = preset_reg;
        alarm_next  = alarm_reg;
        disp        = '0;
        case (step_forced)
            mpas_pkg::STEP_IDLE,
            mpas_pkg::STEP_NORMAL,
            mpas_pkg::STEP_EMERGENCY,
            mpas_pkg::STEP_ERROR:
            begin
                drive_next  = 1'b0;
                active_next = 1'b0;
                run_next    = 1'b0;
            end
            mpas_pkg::STEP_FW_CHECK:
            begin
                if (pin_enabled && fwd_delay_reg != '0)
                begin
                    run_next    = 1'b1;
                    preset_next = TW'(fwd_delay_reg);
                end
            end
            mpas_pkg::STEP_FW_DELAY,
            mpas_pkg::STEP_BW_DELAY:
            begin
                if (q)
                    run_next = 1'b0;
                else
                    disp = 16'(count_next);
            end
            mpas_pkg::STEP_FW_DRIVE:
            begin
                drive_next  = 1'b1;
                active_next = 1'b1;
            end
            mpas_pkg::STEP_BW_CHECK:
            begin
                if (pin_enabled && bwd_delay_reg != '0)
                begin
                    run_next    = 1'b1;
                    preset_next = TW'(bwd_delay_reg);
                end
            end
            mpas_pkg::STEP_BW_ARM:
            begin
                run_next    = 1'b1;
                preset_next = TW'(alarm_preset);
            end
            mpas_pkg::STEP_BW_WATCH:
            begin
                drive_next  = 1'b0;
                active_next = 1'b0;
                disp        = 16'(count_next);
                if (back_limit)
                    run_next = 1'b0;
                if (q)
                    alarm_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign out_data_next = {1'b0, disp, alarm_next, active_next, drive_next, step_next};

    // Hold control state and the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= mpas_pkg::STEP_IDLE;
            drive_reg     <= 1'b0;
            active_reg    <= 1'b0;
            run_reg       <= 1'b0;
            count_reg     <= '0;
            preset_reg    <= '0;
            alarm_reg     <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                step_reg   <= step_next;
                drive_reg  <= drive_next;
                active_reg <= active_next;
                run_reg    <= run_next;
                count_reg  <= count_next;
                preset_reg <= preset_next;
                alarm_reg  <= alarm_next;
            end
        end
    end

    // Capture item payloads
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata;
        if (advance)
            out_data_reg <= out_data_next;
    end

    // The alarm latch only clears on reset
    assert property (@(posedge clk) disable iff (!rst_n) !$fell(alarm_reg))
        else $error("alarm latch cleared without reset");

    // The valve is never driven without the action indicator
    assert property (@(posedge clk) disable iff (!rst_n) drive_reg |-> active_reg)
        else $error("pin driven while action indicator is off");

    // No unused step code is ever reached
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= mpas_pkg::STEP_ERROR)
        else $error("unused step code reached");

    // An empty input register always takes an item
    assert property (@(posedge clk) disable iff (!rst_n) !in_valid_reg |-> s_tready)
        else $error("input stalled with empty input register");

endmodule

// File: verif/mold_pin_actuator_sequencer_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// mold_pin_actuator_sequencer_core_test
// Self-checking bench for the mold pin actuator sequencer. A directed table
// walks the forward and backward phases, stops, the limit-and-timeout race
// and the disable abort. Random control cycles follow in several timing
// setups. Each accepted item is run through a local step model, and every
// result item is compared field by field in arrival order.
// ============================================================================
module mold_pin_actuator_sequencer_core_test;

    localparam int          CYCLE_LIMIT    = 250000;
    localparam int          PHASE_ITEMS    = 140;
    localparam int          PHASE_COUNT    = 6;
    localparam int          PRESSURE_PHASE = 4;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          PLAN_ROWS      = 27;
    localparam logic [2:0]  CMD_UNUSED_LO  = 3'd5;
    localparam logic [2:0]  CMD_UNUSED_HI  = 3'd7;

    // One control cycle, command in the lowest bits
    typedef struct packed {
        logic       auto_mode;
        logic       pin_enabled;
        logic       back_limit;
        logic [7:0] elapsed;
        logic [2:0] command;
    } pin_item_t;

    // One result, step code in the lowest bits
    typedef struct packed {
        logic [mpas_pkg::TIME_WIDTH-1:0] phase_elapsed;
        logic                            not_at_back_alarm;
        logic                            action_active;
        logic                            pin_forward;
        logic [3:0]                      step_code;
    } seq_result_t;

    typedef enum logic { ROW_ITEM, ROW_CONFIG } row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        pin_item_t       item;
        logic            typed;
        seq_result_t     want;
        logic [15:0]     fwd;
        logic [15:0]     bwd;
        logic [15:0]     alarm;
    } plan_row_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_we;
    logic [mpas_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [mpas_pkg::CFG_WIDTH-1:0]       cfg_data;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [mpas_pkg::IN_DATA_WIDTH-1:0]   s_tdata;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [mpas_pkg::OUT_DATA_WIDTH-1:0]  m_tdata;

    // Step model state and timing registers
    mpas_pkg::step_t                 seq_step;
    logic                            pin_drive;
    logic                            pin_active;
    logic                            tmr_run;
    logic [mpas_pkg::TIME_WIDTH-1:0] tmr_count;
    logic [mpas_pkg::TIME_WIDTH-1:0] tmr_preset;
    logic                            back_alarm;
    logic [mpas_pkg::CFG_WIDTH-1:0]  fwd_delay_reg;
    logic [mpas_pkg::CFG_WIDTH-1:0]  bwd_delay_reg;
    logic [mpas_pkg::CFG_WIDTH-1:0]  alarm_time_reg;

    seq_result_t results_due[$];
    plan_row_t   plan [0:PLAN_ROWS-1];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          pressure_armed;
    bit          pressure_done;

    mold_pin_actuator_sequencer_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Step model: one control cycle in, the expected result out
    function automatic seq_result_t advance_sequencer(input pin_item_t it);
        logic [mpas_pkg::TIME_WIDTH:0] sum;
        logic                          done;
        seq_result_t                   r;
        r = '0;
        // a present command forces its step
        case (it.command)
            mpas_pkg::CMD_FORWARD:        seq_step = mpas_pkg::STEP_FW_CHECK;
            mpas_pkg::CMD_BACKWARD:       seq_step = mpas_pkg::STEP_BW_CHECK;
            mpas_pkg::CMD_NORMAL_STOP:    seq_step = mpas_pkg::STEP_NORMAL;
            mpas_pkg::CMD_EMERGENCY_STOP: seq_step = mpas_pkg::STEP_EMERGENCY;
            default: ;
        endcase
        // advance the on-delay timer, saturating at the preset
        if (tmr_run)
        begin
            sum = tmr_count + it.elapsed;
            tmr_count = (sum > tmr_preset) ? tmr_preset
                                           : sum[mpas_pkg::TIME_WIDTH-1:0];
        end
        else
            tmr_count = '0;
        done = tmr_run && (tmr_count >= tmr_preset);
        // run the current step once
        case (seq_step)
            mpas_pkg::STEP_IDLE, mpas_pkg::STEP_ERROR:
            begin
                pin_drive = 1'b0;
                pin_active = 1'b0;
                tmr_run = 1'b0;
            end
            mpas_pkg::STEP_NORMAL, mpas_pkg::STEP_EMERGENCY:
            begin
                pin_drive = 1'b0;
                pin_active = 1'b0;
                tmr_run = 1'b0;
                seq_step = mpas_pkg::STEP_IDLE;
            end
            mpas_pkg::STEP_FW_CHECK:
                if (!it.pin_enabled)
                    seq_step = mpas_pkg::STEP_FW_DONE;
                else if (fwd_delay_reg != '0)
                begin
                    tmr_run = 1'b1;
                    tmr_preset = fwd_delay_reg;
                    seq_step = mpas_pkg::STEP_FW_DELAY;
                end
                else
                    seq_step = mpas_pkg::STEP_FW_DRIVE;
            mpas_pkg::STEP_FW_DELAY:
            begin
                r.phase_elapsed = tmr_count;
                if (done)
                begin
                    tmr_run = 1'b0;
                    r.phase_elapsed = '0;
                    seq_step = mpas_pkg::STEP_FW_DRIVE;
                end
            end
            mpas_pkg::STEP_FW_DRIVE:
            begin
                pin_active = 1'b1;
                pin_drive = 1'b1;
                seq_step = mpas_pkg::STEP_FW_DONE;
            end
            mpas_pkg::STEP_BW_CHECK:
                if (!it.pin_enabled)
                    seq_step = mpas_pkg::STEP_BW_DONE;
                else if (bwd_delay_reg != '0)
                begin
                    tmr_run = 1'b1;
                    tmr_preset = bwd_delay_reg;
                    seq_step = mpas_pkg::STEP_BW_DELAY;
                end
                else
                    seq_step = mpas_pkg::STEP_BW_ARM;
            mpas_pkg::STEP_BW_DELAY:
            begin
                r.phase_elapsed = tmr_count;
                if (done)
                begin
                    tmr_run = 1'b0;
                    r.phase_elapsed = '0;
                    seq_step = mpas_pkg::STEP_BW_ARM;
                end
            end
            mpas_pkg::STEP_BW_ARM:
            begin
                tmr_run = 1'b1;
                tmr_preset = (alarm_time_reg != '0) ? alarm_time_reg
                                                    : mpas_pkg::DEFAULT_ALARM_TIME;
                seq_step = mpas_pkg::STEP_BW_WATCH;
            end
            mpas_pkg::STEP_BW_WATCH:
            begin
                pin_active = 1'b0;
                pin_drive = 1'b0;
                if (it.back_limit)
                begin
                    tmr_run = 1'b0;
                    seq_step = mpas_pkg::STEP_BW_DONE;
                end
                r.phase_elapsed = tmr_count;
                // timeout beats the limit switch
                if (done)
                begin
                    back_alarm = 1'b1;
                    seq_step = mpas_pkg::STEP_ERROR;
                end
            end
            default: ;
        endcase
        // drop the forward phase when disabled in auto
        if ((seq_step == mpas_pkg::STEP_FW_DELAY || seq_step == mpas_pkg::STEP_FW_DRIVE) &&
            !it.pin_enabled && it.auto_mode)
            seq_step = mpas_pkg::STEP_NORMAL;
        r.step_code = seq_step;
        r.pin_forward = pin_drive;
        r.action_active = pin_active;
        r.not_at_back_alarm = back_alarm;
        return r;
    endfunction

    // Random control cycle: mostly plain cycles, some commands and some raw random items
    function automatic pin_item_t draw_control_item();
        pin_item_t   it;
        logic [31:0] noise;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        noise = $urandom;
        it.command = mpas_pkg::CMD_NONE;
        it.elapsed = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 40));
        it.back_limit = ($urandom_range(0, 19) == 0);
        it.pin_enabled = ($urandom_range(0, 24) != 0);
        it.auto_mode = 1'($urandom_range(0, 1));
        if (pick < 5)
        begin
            it.command = mpas_pkg::CMD_FORWARD;
            it.pin_enabled = ($urandom_range(0, 7) != 0);
        end
        else if (pick < 10)
        begin
            it.command = mpas_pkg::CMD_BACKWARD;
            it.pin_enabled = ($urandom_range(0, 7) != 0);
        end
        else if (pick < 12)
            it.command = mpas_pkg::CMD_NORMAL_STOP;
        else if (pick < 14)
            it.command = mpas_pkg::CMD_EMERGENCY_STOP;
        else if (pick < 26)
            it = noise[13:0];
        return it;
    endfunction

    // Offer one item, hold until accepted, then book its expected result
    task automatic offer_item(input pin_item_t it, input logic typed,
                              input seq_result_t want);
        seq_result_t forecast;
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, it};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        forecast = advance_sequencer(it);
        results_due.push_back(typed ? want : forecast);
    endtask

    // Drop valid and wait until every booked result has come back
    task automatic settle_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all three timing registers on consecutive cycles
    task automatic load_timing(input logic [mpas_pkg::CFG_WIDTH-1:0] fwd,
                               input logic [mpas_pkg::CFG_WIDTH-1:0] bwd,
                               input logic [mpas_pkg::CFG_WIDTH-1:0] alarm);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= mpas_pkg::CFG_FORWARD_DELAY;
        cfg_data <= fwd;
        @(negedge clk);
        cfg_index <= mpas_pkg::CFG_BACKWARD_DELAY;
        cfg_data <= bwd;
        @(negedge clk);
        cfg_index <= mpas_pkg::CFG_BACK_ALARM_TIME;
        cfg_data <= alarm;
        @(negedge clk);
        cfg_we <= 1'b0;
        fwd_delay_reg = fwd;
        bwd_delay_reg = bwd;
        alarm_time_reg = alarm;
    endtask

    // Result side: random stalls, plus one long hold-off when armed
    initial
    begin
        m_tready = 1'b0;
        pressure_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_armed && !pressure_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                pressure_done = 1'b1;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Compare each result item with the oldest booked one
    always @(posedge clk)
    begin : watch_results
        seq_result_t got;
        seq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[22:0];
            if (results_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result item: step %0d elapsed %0d",
                             got.step_code, got.phase_elapsed);
            end
            else
            begin
                want = results_due.pop_front();
                if (got.step_code != want.step_code ||
                    got.pin_forward != want.pin_forward ||
                    got.action_active != want.action_active ||
                    got.not_at_back_alarm != want.not_at_back_alarm ||
                    got.phase_elapsed != want.phase_elapsed)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch (exp/act): step %0d/%0d fwd %0b/%0b ",
                                  "active %0b/%0b alarm %0b/%0b elapsed %0d/%0d"},
                                 want.step_code, got.step_code,
                                 want.pin_forward, got.pin_forward,
                                 want.action_active, got.action_active,
                                 want.not_at_back_alarm, got.not_at_back_alarm,
                                 want.phase_elapsed, got.phase_elapsed);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [mpas_pkg::CFG_WIDTH-1:0] fwd;
        logic [mpas_pkg::CFG_WIDTH-1:0] bwd;
        logic [mpas_pkg::CFG_WIDTH-1:0] alarm;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mpas_pkg::CFG_FORWARD_DELAY;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        pressure_armed = 1'b0;
        tx_idle_pct = 32;
        rx_idle_pct = 87;
        seq_step = mpas_pkg::STEP_IDLE;
        pin_drive = 1'b0;
        pin_active = 1'b0;
        tmr_run = 1'b0;
        tmr_count = '0;
        tmr_preset = '0;
        back_alarm = 1'b0;
        fwd_delay_reg = '0;
        bwd_delay_reg = '0;
        alarm_time_reg = mpas_pkg::DEFAULT_ALARM_TIME;

        // item fields: auto, enable, limit, elapsed, command
        // result fields: elapsed, alarm, active, forward, step
        plan = '{
            // idle after reset, then an unknown command at the field extremes
            '{ROW_ITEM, '{1'b0, 1'b0, 1'b0, 8'd0, mpas_pkg::CMD_NONE}, 1'b1,
              '{16'd0, 1'b0, 1'b0, 1'b0, mpas_pkg::STEP_IDLE}, '0, '0, '0},
            '{ROW_ITEM, '{1'b1, 1'b1, 1'b1, 8'd255, CMD_UNUSED_HI}, 1'b1,
              '{16'd0, 1'b0, 1'b0, 1'b0, mpas_pkg::STEP_IDLE}, '0, '0, '0},
            // forward while disabled, then enabled and held
            '{ROW_ITEM, '{1'b0, 1'b0, 1'b0, 8'd0, mpas_pkg::CMD_FORWARD}, 1'b1,
              '{16'd0, 1'b0, 1'b0, 1'b0, mpas_pkg::STEP_FW_DONE}, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd0, mpas_pkg::CMD_FORWARD}, 1'b1,
              '{16'd0, 1'b0, 1'b0, 1'b0, mpas_pkg::STEP_FW_DRIVE}, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd7, mpas_pkg::CMD_FORWARD}, 1'b1,
              '{16'd0, 1'b0, 1'b0, 1'b0, mpas_pkg::STEP_FW_DRIVE}, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd0, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd0, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            // backward into the watch, limit and timeout on the same cycle
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd0, mpas_pkg::CMD_BACKWARD}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd0, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd255, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd255, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd255, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b1, 8'd255, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            // error stop holds until a real command
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd3, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b1, 1'b0, 1'b0, 8'd9, CMD_UNUSED_LO}, 1'b0, '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b0, 1'b0, 8'd0, mpas_pkg::CMD_NORMAL_STOP}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b0, 1'b0, 8'd0, mpas_pkg::CMD_BACKWARD}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b0, 1'b0, 8'd0, mpas_pkg::CMD_EMERGENCY_STOP}, 1'b0,
              '0, '0, '0, '0},
            // delays on, zero alarm time falls back to the default
            '{ROW_CONFIG, '0, 1'b0, '0, 16'd300, 16'd2, 16'd0},
            '{ROW_ITEM, '{1'b1, 1'b1, 1'b0, 8'd0, mpas_pkg::CMD_FORWARD}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b1, 1'b1, 1'b0, 8'd200, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            // disable in auto during the forward delay
            '{ROW_ITEM, '{1'b1, 1'b0, 1'b0, 8'd50, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd0, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd0, mpas_pkg::CMD_BACKWARD}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd255, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b0, 8'd0, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0},
            '{ROW_ITEM, '{1'b0, 1'b1, 1'b1, 8'd10, mpas_pkg::CMD_NONE}, 1'b0,
              '0, '0, '0, '0}
        };

        // hold reset, release on a falling edge
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CONFIG)
            begin
                settle_block();
                load_timing(plan[i].fwd, plan[i].bwd, plan[i].alarm);
            end
            else
                offer_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        // random phases, each under its own timing setup
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            settle_block();
            if (p == 0)
            begin
                fwd = 16'hFFFF;
                bwd = 16'd0;
                alarm = 16'd1;
            end
            else if (p == 1)
            begin
                fwd = 16'd0;
                bwd = 16'hFFFF;
                alarm = 16'hFFFF;
            end
            else
            begin
                fwd = 16'($urandom_range(0, 700));
                bwd = 16'($urandom_range(0, 700));
                alarm = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 1200));
            end
            load_timing(fwd, bwd, alarm);
            if (p < 2)
            begin
                tx_idle_pct = 32;
                rx_idle_pct = 87;
            end
            else if (p < 4)
            begin
                tx_idle_pct = 87;
                rx_idle_pct = 32;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == PRESSURE_PHASE)
                pressure_armed = 1'b1;
            repeat (PHASE_ITEMS)
                offer_item(draw_control_item(), 1'b0, '0);
        end

        // drain and report
        settle_block();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
